/* sv/assert_macros.svh */
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lifomx_pkg.sv */
// shared types, sizes and helpers of the lifo stack with max query
`timescale 1ns / 1ps

package lifomx_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_MAX  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // key whose unsigned order follows the selected order of words
  function automatic word_t ord_key(input word_t w, input logic sgn);
    word_t k;
    k = w;
    k[WORD_BITS-1] = w[WORD_BITS-1] ^ sgn;
    return k;
  endfunction

endpackage

/* sv/lifomx_ram.sv */
// simple dual-port ram with registered read data
`timescale 1ns / 1ps

module lifomx_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH_P = 32,
  parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/lifo_stack_with_max_query.sv */
// top level: lifo stack of words with pop, peek and max scan
//
// Input channel in_valid/in_stall carries one request per beat: in_kind
// (push, pop, peek, max) and in_value (word to push). Result channel
// out_valid/out_stall returns exactly one beat per request: out_result_value,
// out_status (ok, empty, overflow) and out_fill_count after the request.
// cfg_valid/cfg_ready writes cfg_signed_order (0 unsigned, 1 two's complement
// order for the max scan); cfg_ready is always high.
// Timing: push, and any request on an empty stack, is decided in the cycle it
// is taken; pop and peek wait for the registered memory read; a max scan
// reads one entry per cycle from the bottom up. The next request is taken
// the cycle after the result is loaded, so a pop, peek or scan finishes
// before the next request is accepted.
// A finished result sits in the output register; while out_stall holds it,
// the next request may still be taken and runs until its own result is ready,
// then waits. Synchronous reset empties the stack and clears the output valid;
// the entry memory is not cleared and needs no sweep.
`timescale 1ns / 1ps

module lifo_stack_with_max_query
  import lifomx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic [1:0]  out_status,
  output logic [8:0]  out_fill_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_signed_order
);

`include "assert_macros.svh"

  localparam cnt_t CNT_FULL = CNT_BITS'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_FIN
  } state_t;

  state_t      state_r, state_nxt;
  cnt_t        count_r, count_nxt;
  cnt_t        idx_r, idx_nxt;
  word_t       best_r, best_nxt;
  word_t       res_r, res_nxt;
  status_t     status_r, status_nxt;
  logic        sgn_r, sgn_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_res_r, out_res_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [8:0]  out_fill_r, out_fill_nxt;

  logic        mem_we;
  addr_t       mem_waddr;
  word_t       mem_wdata;
  logic        mem_re;
  addr_t       mem_raddr;
  word_t       rd_q;

  logic        acc;
  logic        out_free;
  cnt_t        cnt_dec;
  word_t       best_cand;
  logic        take;

  // entry memory
  lifomx_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_q)
  );

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign cnt_dec   = count_r - 1'b1;

  // max scan compare, earlier entry wins a tie
  assign take      = (idx_r == cnt_t'(1)) || (ord_key(rd_q, sgn_r) > ord_key(best_r, sgn_r));
  assign best_cand = take ? rd_q : best_r;

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    res_nxt        = res_r;
    status_nxt     = status_r;
    sgn_nxt        = (cfg_valid && cfg_ready) ? cfg_signed_order : sgn_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[ADDR_BITS-1:0];
    mem_wdata      = word_t'(in_value);
    mem_re         = 1'b0;
    mem_raddr      = cnt_dec[ADDR_BITS-1:0];

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (kind_t'(in_kind) == KIND_PUSH || count_r == '0) begin
            // result known at once: push or request on empty stack
            res_nxt = '0;
            if (kind_t'(in_kind) != KIND_PUSH) begin
              status_nxt = ST_EMPTY;
            end else if (count_r >= CNT_FULL) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              status_nxt = ST_OK;
              mem_we     = 1'b1;
              count_nxt  = count_r + 1'b1;
            end
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_res_nxt    = '0;
              out_status_nxt = status_nxt;
              out_fill_nxt   = 9'(count_nxt);
            end else begin
              state_nxt = S_FIN;
            end
          end else begin
            case (kind_t'(in_kind))
              KIND_POP: begin
                mem_re    = 1'b1;
                count_nxt = cnt_dec;
                state_nxt = S_RD;
              end
              KIND_PEEK: begin
                mem_re    = 1'b1;
                state_nxt = S_RD;
              end
              KIND_MAX: begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = cnt_t'(1);
                state_nxt = S_SCAN;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_RD: begin
        // read data holds until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = 32'(rd_q);
          out_status_nxt = ST_OK;
          out_fill_nxt   = 9'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        // rd_q holds entry idx_r-1
        if (idx_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r[ADDR_BITS-1:0];
          idx_nxt   = idx_r + 1'b1;
          best_nxt  = best_cand;
        end else begin
          res_nxt    = best_cand;
          status_nxt = ST_OK;
          state_nxt  = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = 32'(res_r);
          out_status_nxt = status_r;
          out_fill_nxt   = 9'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sgn_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sgn_r       <= sgn_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    best_r       <= best_nxt;
    res_r        <= res_nxt;
    status_r     <= status_nxt;
    out_res_r    <= out_res_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_status_r;
  assign out_fill_count   = out_fill_r;

  // checks
  `ASSERT_IMPL(a_count_range, 1'b1, count_r <= CNT_FULL, "entry count above depth")
  `ASSERT_NEXT(a_push_grows, acc && kind_t'(in_kind) == KIND_PUSH && count_r < CNT_FULL,
               count_r == $past(count_r) + 1'b1, "push did not grow the stack")
  `ASSERT_IMPL(a_ovf_full, out_valid_r && out_status_r == ST_OVERFLOW,
               out_fill_r == 9'(DEPTH), "overflow reported on a stack not full")
  `ASSERT_IMPL(a_err_zero, out_valid_r && out_status_r != ST_OK,
               out_res_r == '0, "nonzero value with error status")
  `ASSERT_IMPL(a_scan_idx, state_r == S_SCAN,
               idx_r != '0 && idx_r <= count_r, "scan index outside held entries")

endmodule
